/* design/fixed_partition_fit_allocator_defines.svh */
// Assertion macros for the fixed partition fit allocator.
// Needs a clock named clk and an active-low reset named rst_n in the calling scope.
`ifndef FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH
`define FIXED_PARTITION_FIT_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, disabled while in reset.
`define FPFA_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("fpfa assertion failed");

// Next-cycle implication, disabled while in reset.
`define FPFA_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("fpfa assertion failed");

`endif

/* design/fpfa_pkg.sv */
// Shared constants, codes and controller/datapath interface types for the
// fixed partition fit allocator. No dependencies.
package fpfa_pkg;

    localparam int DEF_MAX_PARTITIONS = 256;
    localparam int DEF_SIZE_BITS      = 16;

    localparam int TOTAL_W = 24;
    localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

    localparam int FIT_W = 2;
    localparam logic [FIT_W-1:0] FIT_FIRST = 2'd0;
    localparam logic [FIT_W-1:0] FIT_BEST  = 2'd1;
    localparam logic [FIT_W-1:0] FIT_WORST = 2'd2;

    localparam logic KIND_LOAD    = 1'b0;
    localparam logic KIND_REQUEST = 1'b1;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_FIT_MODE     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_PARTS_IN_USE = 1'b1;

    typedef struct packed {
        logic capture;     // latch the accepted item
        logic load_write;  // write the size table for a load item
        logic scan_clear;  // reset address, accumulators and search state
        logic scan_issue;  // read the next table entry
        logic finish;      // commit the pick and load the result register
    } ctrl_cmd_t;

    typedef struct packed {
        logic is_load;
        logic scan_empty;
        logic scan_last;
        logic out_free;
    } dp_status_t;

endpackage

/* design/fpfa_ctrl.sv */
// Sequencing state machine for the fixed partition fit allocator.
// Uses fpfa_pkg for the command and status types.
module fpfa_ctrl
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  fpfa_pkg::dp_status_t   status,
    output fpfa_pkg::ctrl_cmd_t    cmd
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PREP,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   item_stall_reg;
    logic   item_stall_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = ST_PREP;
                end
            end
            ST_PREP:
            begin
                cmd.load_write = status.is_load;
                cmd.scan_clear = 1'b1;
                state_next     = status.scan_empty ? ST_DONE : ST_SCAN;
            end
            ST_SCAN:
            begin
                cmd.scan_issue = 1'b1;
                if (status.scan_last)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (status.out_free)
                begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        item_stall_next = (state_next != ST_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            item_stall_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            item_stall_reg <= item_stall_next;
        end
    end

    assign item_stall = item_stall_reg;

endmodule

/* design/fpfa_dp.sv */
// Datapath of the fixed partition fit allocator: partition tables, scan,
// fit search, running totals and result register. Uses fpfa_pkg and the defines header.
`include "fixed_partition_fit_allocator_defines.svh"

module fpfa_dp
#(
    parameter int MAX_PARTITIONS = fpfa_pkg::DEF_MAX_PARTITIONS,
    parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS,
    parameter int IDX_W          = $clog2(MAX_PARTITIONS),
    parameter int CNT_W          = $clog2(MAX_PARTITIONS + 1)
)
(
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [CNT_W-1:0]                    cfg_data,
    // item
    input  logic                                kind,
    input  logic [IDX_W-1:0]                    partition_index,
    input  logic [SIZE_BITS-1:0]                amount,
    // result
    output logic                                res_valid,
    input  logic                                res_stall,
    output logic                                granted,
    output logic [IDX_W-1:0]                    chosen_partition,
    output logic [SIZE_BITS-1:0]                partition_waste,
    output logic [fpfa_pkg::TOTAL_W-1:0]        internal_total,
    output logic [fpfa_pkg::TOTAL_W-1:0]        free_total,
    output logic                                any_refused,
    // controller
    input  fpfa_pkg::ctrl_cmd_t                 cmd,
    output fpfa_pkg::dp_status_t                status
);

    localparam int ACC_W = SIZE_BITS + IDX_W + 1;
    localparam int CMP_W = (ACC_W > fpfa_pkg::TOTAL_W) ? ACC_W : fpfa_pkg::TOTAL_W;

    // configuration registers
    logic [fpfa_pkg::FIT_W-1:0] fit_mode_reg;
    logic [CNT_W-1:0]           in_use_reg;
    logic [CNT_W-1:0]           n_eff;

    // captured item
    logic                 kind_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [SIZE_BITS-1:0] amt_reg;

    // tables
    logic [SIZE_BITS-1:0] size_mem  [MAX_PARTITIONS];
    logic [SIZE_BITS-1:0] waste_mem [MAX_PARTITIONS];
    logic                 taken_reg [MAX_PARTITIONS];

    // scan
    logic [IDX_W-1:0]     addr_reg;
    logic                 rd_valid_reg;
    logic [IDX_W-1:0]     rd_idx_reg;
    logic [SIZE_BITS-1:0] size_rd_reg;
    logic [SIZE_BITS-1:0] waste_rd_reg;
    logic                 taken_rd_reg;

    // search and totals
    logic                 found_reg;
    logic [IDX_W-1:0]     pick_reg;
    logic [SIZE_BITS-1:0] best_reg;
    logic [ACC_W-1:0]     acc_waste_reg;
    logic [ACC_W-1:0]     acc_free_reg;
    logic                 refused_reg;

    logic                 load_ok;
    logic                 fits;
    logic                 better;
    logic                 take;
    logic                 grant;
    logic [SIZE_BITS-1:0] pick_waste;
    logic [ACC_W-1:0]     waste_adj;
    logic [ACC_W-1:0]     free_adj;
    logic [CMP_W-1:0]     waste_wide;
    logic [CMP_W-1:0]     free_wide;
    logic [fpfa_pkg::TOTAL_W-1:0] waste_sat;
    logic [fpfa_pkg::TOTAL_W-1:0] free_sat;

    // result register
    logic                 res_valid_reg;
    logic                 granted_reg;
    logic [IDX_W-1:0]     chosen_reg;
    logic [SIZE_BITS-1:0] pwaste_reg;
    logic [fpfa_pkg::TOTAL_W-1:0] internal_reg;
    logic [fpfa_pkg::TOTAL_W-1:0] free_reg;
    logic                 refused_out_reg;

    assign n_eff = (in_use_reg > CNT_W'(MAX_PARTITIONS)) ? CNT_W'(MAX_PARTITIONS) : in_use_reg;
    assign load_ok = (CNT_W'(idx_reg) < CNT_W'(MAX_PARTITIONS));

    assign status.is_load    = (kind_reg == fpfa_pkg::KIND_LOAD);
    assign status.scan_empty = (n_eff == '0);
    assign status.scan_last  = (CNT_W'(addr_reg) == (n_eff - CNT_W'(1)));
    assign status.out_free   = !res_valid_reg || !res_stall;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fit_mode_reg <= fpfa_pkg::FIT_FIRST;
            in_use_reg   <= '0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                fpfa_pkg::CFG_FIT_MODE:     fit_mode_reg <= cfg_data[fpfa_pkg::FIT_W-1:0];
                fpfa_pkg::CFG_PARTS_IN_USE: in_use_reg   <= cfg_data;
                default:                    in_use_reg   <= in_use_reg;
            endcase
        end
    end

    // item capture
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg <= kind;
            idx_reg  <= partition_index;
            amt_reg  <= amount;
        end
    end

    // size table
    always_ff @(posedge clk)
    begin
        if (cmd.load_write && load_ok)
            size_mem[idx_reg] <= amt_reg;
        size_rd_reg <= size_mem[addr_reg];
    end

    // per-partition waste table, written on a grant
    always_ff @(posedge clk)
    begin
        if (cmd.finish && grant)
            waste_mem[pick_reg] <= pick_waste;
        waste_rd_reg <= waste_mem[addr_reg];
    end

    // taken bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_PARTITIONS; i++)
                taken_reg[i] <= 1'b0;
        end
        else if (cmd.load_write && load_ok)
            taken_reg[idx_reg] <= 1'b0;
        else if (cmd.finish && grant)
            taken_reg[pick_reg] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        taken_rd_reg <= taken_reg[addr_reg];
        rd_idx_reg   <= addr_reg;
    end

    // fit decision on the entry read last cycle
    assign fits = !taken_rd_reg && (size_rd_reg >= amt_reg);

    always_comb
    begin
        unique case (fit_mode_reg)
            fpfa_pkg::FIT_BEST:  better = !found_reg || (size_rd_reg < best_reg);
            fpfa_pkg::FIT_WORST: better = !found_reg || (size_rd_reg >= best_reg);
            default:             better = !found_reg;
        endcase
    end

    assign take = rd_valid_reg && fits && better;

    // scan address, search state and raw totals
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            acc_waste_reg <= '0;
            acc_free_reg  <= '0;
            pick_reg      <= '0;
            best_reg      <= '0;
        end
        else if (cmd.scan_clear)
        begin
            addr_reg      <= '0;
            rd_valid_reg  <= 1'b0;
            found_reg     <= 1'b0;
            acc_waste_reg <= '0;
            acc_free_reg  <= '0;
        end
        else
        begin
            rd_valid_reg <= cmd.scan_issue;
            if (cmd.scan_issue)
                addr_reg <= IDX_W'(addr_reg + 1'b1);
            if (rd_valid_reg)
            begin
                if (taken_rd_reg)
                    acc_waste_reg <= acc_waste_reg + ACC_W'(waste_rd_reg);
                else
                    acc_free_reg  <= acc_free_reg + ACC_W'(size_rd_reg);
            end
            if (take)
            begin
                found_reg <= 1'b1;
                pick_reg  <= rd_idx_reg;
                best_reg  <= size_rd_reg;
            end
        end
    end

    // the scan saw the picked partition as free: move it across
    assign grant      = (kind_reg == fpfa_pkg::KIND_REQUEST) && found_reg;
    assign pick_waste = best_reg - amt_reg;
    assign waste_adj  = grant ? (acc_waste_reg + ACC_W'(pick_waste)) : acc_waste_reg;
    assign free_adj   = grant ? (acc_free_reg - ACC_W'(best_reg)) : acc_free_reg;
    assign waste_wide = CMP_W'(waste_adj);
    assign free_wide  = CMP_W'(free_adj);
    assign waste_sat  = (waste_wide > CMP_W'(fpfa_pkg::TOTAL_MAX)) ? fpfa_pkg::TOTAL_MAX
                                                                 : waste_wide[fpfa_pkg::TOTAL_W-1:0];
    assign free_sat   = (free_wide > CMP_W'(fpfa_pkg::TOTAL_MAX)) ? fpfa_pkg::TOTAL_MAX
                                                                : free_wide[fpfa_pkg::TOTAL_W-1:0];

    // sticky refusal and result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            refused_reg   <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.finish && (kind_reg == fpfa_pkg::KIND_REQUEST) && !found_reg)
                refused_reg <= 1'b1;
            if (cmd.finish)
                res_valid_reg <= 1'b1;
            else if (!res_stall)
                res_valid_reg <= 1'b0;
        end
    end

    // result payload
    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            granted_reg     <= grant;
            chosen_reg      <= grant ? pick_reg : '0;
            pwaste_reg      <= grant ? pick_waste : '0;
            internal_reg    <= waste_sat;
            free_reg        <= free_sat;
            refused_out_reg <= refused_reg || ((kind_reg == fpfa_pkg::KIND_REQUEST) && !found_reg);
        end
    end

    assign res_valid        = res_valid_reg;
    assign granted          = granted_reg;
    assign chosen_partition = chosen_reg;
    assign partition_waste  = pwaste_reg;
    assign internal_total   = internal_reg;
    assign free_total       = free_reg;
    assign any_refused      = refused_out_reg;

    // entries read by the scan lie inside the partitions in use
    `FPFA_ASSERT_IMPL(a_scan_in_range, rd_valid_reg, CNT_W'(rd_idx_reg) < n_eff)
    // a granted result names a partition inside the partitions in use
    `FPFA_ASSERT_NEXT(a_grant_in_range, cmd.finish && grant, res_valid_reg && granted_reg && (CNT_W'(chosen_reg) < n_eff))
    // once set, refusal never clears
    `FPFA_ASSERT_NEXT(a_refused_sticky, refused_reg, refused_reg)

endmodule

/* design/fixed_partition_fit_allocator.sv */
// Fixed partition allocator: an accepted item steps through prep, scan, drain and done;
// scan reads N = min(partitions_in_use, MAX_PARTITIONS) entries; N = 0 skips to done.
// One partition is read per cycle from the size and waste tables, which serves both
// the fit search and the recount of the totals; new items stall until done finishes.
// Asynchronous active-low reset frees every partition, clears totals, refusal flag
// and configuration; partition sizes are undefined until loaded. No clearing pass.
//
// Top level: joins fpfa_ctrl and fpfa_dp. Uses fpfa_pkg.
//
// Every item returns one result transaction. The result register parts the two sides,
// so the next item transaction is taken while a result still waits on res_stall.
// The totals are summed over the scan as seen before the pick; on a grant the picked
// partition's size leaves the free sum and its waste joins the waste sum before
// saturation, which equals the per-step clamp since all terms are non-negative.
// The configuration port is always ready; writes are expected only while idle.
module fixed_partition_fit_allocator
#(
    parameter int MAX_PARTITIONS = fpfa_pkg::DEF_MAX_PARTITIONS,
    parameter int SIZE_BITS      = fpfa_pkg::DEF_SIZE_BITS,
    parameter int IDX_W          = $clog2(MAX_PARTITIONS),
    parameter int CNT_W          = $clog2(MAX_PARTITIONS + 1)
)
(
    input  logic                            clk,
    input  logic                            rst_n,
    // configuration write channel
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [fpfa_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [CNT_W-1:0]                cfg_data,
    // item channel
    input  logic                            item_valid,
    output logic                            item_stall,
    input  logic                            kind,
    input  logic [IDX_W-1:0]                partition_index,
    input  logic [SIZE_BITS-1:0]            amount,
    // result channel
    output logic                            res_valid,
    input  logic                            res_stall,
    output logic                            granted,
    output logic [IDX_W-1:0]                chosen_partition,
    output logic [SIZE_BITS-1:0]            partition_waste,
    output logic [fpfa_pkg::TOTAL_W-1:0]    internal_total,
    output logic [fpfa_pkg::TOTAL_W-1:0]    free_total,
    output logic                            any_refused
);

    fpfa_pkg::ctrl_cmd_t  cmd;
    fpfa_pkg::dp_status_t status;

    assign cfg_ready = 1'b1;

    fpfa_ctrl u_ctrl
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .status     (status),
        .cmd        (cmd)
    );

    fpfa_dp
    #(
        .MAX_PARTITIONS (MAX_PARTITIONS),
        .SIZE_BITS      (SIZE_BITS),
        .IDX_W          (IDX_W),
        .CNT_W          (CNT_W)
    )
    u_dp
    (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid && cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .kind             (kind),
        .partition_index  (partition_index),
        .amount           (amount),
        .res_valid        (res_valid),
        .res_stall        (res_stall),
        .granted          (granted),
        .chosen_partition (chosen_partition),
        .partition_waste  (partition_waste),
        .internal_total   (internal_total),
        .free_total       (free_total),
        .any_refused      (any_refused),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
